[src/cxpd_pkg.sv]
// ----------------------------------------------------------------------------
// cxpd_pkg
// Shared types for the chained xor packet decoder: input request, result
// and the chain state carried from byte to byte.
// ----------------------------------------------------------------------------
`default_nettype none

package cxpd_pkg;

    localparam int ByteW = 8;

    typedef logic [ByteW-1:0] t_byte;

    // one encrypted byte as it enters the block
    typedef struct packed {
        t_byte data_byte;
        t_byte rand_key;
        logic  is_first;
        logic  is_last;
    } t_in_req;

    // one decoded byte as it leaves the block
    typedef struct packed {
        t_byte plain_byte;
        logic  is_checksum;
        logic  last;
        logic  checksum_ok;
    } t_out_req;

    // chain state kept between bytes of a packet
    typedef struct packed {
        t_byte prev_cipher;
        t_byte prev_mid;
        t_byte position;
        t_byte payload_sum;
        t_byte expected_sum;
        t_byte packet_rand_key;
    } t_chain_state;

    localparam t_byte FirstPos = t_byte'(1);

endpackage

`default_nettype wire

[src/cxpd_decode.sv]
// ----------------------------------------------------------------------------
// cxpd_decode
// Decodes one byte against the current chain state and gives the result
// together with the next chain state. Two 8-bit add/xor stages and the
// running payload checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cxpd_decode (
    input  wire cxpd_pkg::t_byte        i_packet_key,
    input  wire cxpd_pkg::t_in_req      i_req,
    input  wire cxpd_pkg::t_chain_state i_state,
    output cxpd_pkg::t_out_req          o_res,
    output cxpd_pkg::t_chain_state      o_state
);
    import cxpd_pkg::*;

    t_byte pos;
    t_byte base_cipher;
    t_byte base_mid;
    t_byte rkey;
    t_byte base_sum;
    t_byte mid;
    t_byte plain;
    t_byte next_sum;
    t_byte next_expected;

    // packet start clears the chain and takes the fresh random key
    always_comb begin
        if (i_req.is_first) begin
            pos         = FirstPos;
            base_cipher = '0;
            base_mid    = '0;
            rkey        = i_req.rand_key;
            base_sum    = '0;
        end else begin
            pos         = i_state.position + FirstPos;
            base_cipher = i_state.prev_cipher;
            base_mid    = i_state.prev_mid;
            rkey        = i_state.packet_rand_key;
            base_sum    = i_state.payload_sum;
        end
    end

    // two chained stages, all sums wrap at 8 bits
    assign mid   = i_req.data_byte ^ t_byte'(base_cipher + i_packet_key + pos);
    assign plain = mid ^ t_byte'(base_mid + rkey + pos);

    // checksum byte is remembered, payload bytes are accumulated
    assign next_expected = i_req.is_first ? plain : i_state.expected_sum;
    assign next_sum      = i_req.is_first ? base_sum : t_byte'(base_sum + plain);

    assign o_state.prev_cipher     = i_req.data_byte;
    assign o_state.prev_mid        = mid;
    assign o_state.position        = pos;
    assign o_state.payload_sum     = next_sum;
    assign o_state.expected_sum    = next_expected;
    assign o_state.packet_rand_key = rkey;

    assign o_res.plain_byte  = plain;
    assign o_res.is_checksum = i_req.is_first;
    assign o_res.last        = i_req.is_last;
    assign o_res.checksum_ok = i_req.is_last && (next_sum == next_expected);

endmodule

`default_nettype wire

[src/chained_xor_packet_decoder_core.sv]
// ----------------------------------------------------------------------------
// chained_xor_packet_decoder_core
// Byte stream decoder for chained xor encrypted packets with checksum check.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall  | data_byte rand_key first last
//   out     | output    | o_out_valid / i_out_stall| plain_byte is_checksum last ok
//   cfg     | input     | i_cfg_valid / o_cfg_ready| packet_key
//
// Two register stages: input register, then decode into the result register.
// One byte per cycle sustained while the output is not stalled.
// Chain state is updated as a byte moves into the result register, so the
// next byte in the input register always sees it.
// Synchronous active-low reset clears valids, chain state and the key.
// An output stall holds the result register and backs up into the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_xor_packet_decoder_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire cxpd_pkg::t_byte i_data_byte,
    input  wire cxpd_pkg::t_byte i_rand_key,
    input  wire                  i_is_first,
    input  wire                  i_is_last,
    // output channel
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output cxpd_pkg::t_byte      o_plain_byte,
    output logic                 o_is_checksum,
    output logic                 o_last,
    output logic                 o_checksum_ok,
    // configuration channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire cxpd_pkg::t_byte i_cfg_data
);
    import cxpd_pkg::*;

    logic         r_in_valid;
    t_in_req      r_in_req;
    logic         r_out_valid;
    t_out_req     r_out_req;
    t_chain_state r_state;
    t_byte        r_packet_key;

    t_out_req     n_out_req;
    t_chain_state n_state;
    logic         advance;
    logic         in_take;

    // pipeline moves when the result register is empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // key register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_packet_key <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req.data_byte <= i_data_byte;
            r_in_req.rand_key  <= i_rand_key;
            r_in_req.is_first  <= i_is_first;
            r_in_req.is_last   <= i_is_last;
        end
    end

    // decode step
    cxpd_decode u_decode (
        .i_packet_key (r_packet_key),
        .i_req        (r_in_req),
        .i_state      (r_state),
        .o_res        (n_out_req),
        .o_state      (n_state)
    );

    // chain state follows each decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_plain_byte  = r_out_req.plain_byte;
    assign o_is_checksum = r_out_req.is_checksum;
    assign o_last        = r_out_req.last;
    assign o_checksum_ok = r_out_req.checksum_ok;

endmodule

`default_nettype wire

[src/cxpd_checker.sv]
// ----------------------------------------------------------------------------
// cxpd_checker
// Port-level checks for the chained xor packet decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cxpd_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [7:0] o_plain_byte,
    input wire       o_is_checksum,
    input wire       o_last,
    input wire       o_checksum_ok
);

    // a stalled result request stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // input side only backs up behind a stalled full result register
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without an output stall");

    // checksum flag only on the final byte
    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_checksum_ok |-> o_last)
        else $error("checksum_ok raised outside last byte");

    // empty payload: ok exactly when the decoded checksum is zero
    a_empty_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_checksum && o_last |->
            (o_checksum_ok == (o_plain_byte == 8'd0)))
        else $error("empty packet checksum mismatch");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind chained_xor_packet_decoder_core cxpd_checker u_cxpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_plain_byte  (o_plain_byte),
    .o_is_checksum (o_is_checksum),
    .o_last        (o_last),
    .o_checksum_ok (o_checksum_ok)
);

`default_nettype wire
